### hw/rtl/unit_cost_estimator_core_assert.svh
// ---------------------------------------------------------------------------
// unit cost estimator assertion macros
// concurrent assertion wrappers, empty when synthesising
// ---------------------------------------------------------------------------
`ifndef UNIT_COST_ESTIMATOR_CORE_ASSERT_SVH
`define UNIT_COST_ESTIMATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// checked property, masked while reset is high
`define UCEST_ASSERT_RST(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("unit_cost_estimator_core: assertion failed");
// checked property, live during reset as well
`define UCEST_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("unit_cost_estimator_core: assertion failed");
`else
`define UCEST_ASSERT_RST(lbl, clk, rst, prop)
`define UCEST_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### hw/rtl/ucest_pkg.sv
// ---------------------------------------------------------------------------
// ucest_pkg
// shared widths, codes and divider handshake types of the cost estimator
// ---------------------------------------------------------------------------
package ucest_pkg;

  // samples averaged when the estimate is seeded
  localparam int SAMPLES = 16;
  localparam int CNT_W   = $clog2(SAMPLES + 1);
  localparam int SMP_AW  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

  localparam int COST_W  = 48;
  localparam int COUNT_W = 31;
  localparam int SCALE_W = 16;
  localparam int LIM_W   = COST_W + 4;       // ten times a cost
  localparam int SUM_W   = COST_W + CNT_W;   // sum of all samples
  localparam int PROD_W  = COST_W + SCALE_W;

  // divider: dividend must hold 9*estimate+cost and the sample sum
  localparam int DIV_RAW   = (SUM_W > COST_W + 5) ? SUM_W : COST_W + 5;
  localparam int DIV_W     = DIV_RAW + (DIV_RAW % 2);
  localparam int DVS_W     = COUNT_W;
  localparam int DIV_STEPS = DIV_W / 2;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam int AVG_DIVISOR   = 10;
  localparam int OUTLIER_RATIO = 10;

  // configuration port
  localparam int APB_AW = 4;
  localparam int APB_DW = 64;
  localparam int CFG_IDX_BIT = 3;

  localparam logic [COST_W-1:0]  INITIAL_COST_RST = COST_W'(10000);
  localparam logic [SCALE_W-1:0] POOL_SCALE_RST   = SCALE_W'(256);
  localparam logic [COST_W-1:0]  COST_MAX         = {COST_W{1'b1}};

  typedef enum logic {
    REG_INITIAL_COST = 1'b0,
    REG_POOL_SCALE   = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_INIT = 2'd1,
    PH_WORK = 2'd2
  } phase_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

### hw/rtl/unit_cost_estimator_core.sv
// ---------------------------------------------------------------------------
// unit_cost_estimator_core
// per-unit cost estimator with outlier rejection and moving average
// ---------------------------------------------------------------------------
// Each measurement (elapsed ns, unit count) yields exactly one result: the
// estimate after the step, the estimate times the Q8.8 pool factor (floored,
// saturated to 48 bits) and the phase. The first 17 measurements are
// dropped, the next 16 per-unit costs go into a 16-entry sample ram, the one
// after that seeds the estimate from the ram and every later one updates it
// as floor((9*est + cost)/10), skipping costs above ten times the estimate.
// Items are handled one at a time. All division goes through one shared
// divider that retires two quotient bits a cycle. Every measurement starts
// with the per-unit cost divide; in the tracking phase an average divide
// follows unless the cost is an outlier, and the seeding measurement adds
// two scans of the ram (minimum, then sum) and, if any sample qualifies,
// the mean divide. A finished result sits in the output register while the
// next measurement is taken in. The sample ram has no reset; every entry is
// written before the seed scan reads it. The user must write configuration
// over the apb port (initial_cost at 0x0, pool_scale at 0x8; only address
// bit 3 decoded) only while the block is idle; the block never enforces it.
// ---------------------------------------------------------------------------
`include "unit_cost_estimator_core_assert.svh"

module unit_cost_estimator_core (
  input  logic                          clk,
  input  logic                          rst,
  // measurement stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [79:0]                   s_axis_tdata,   // elapsed_ns[47:0], unit_count[78:48]
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [103:0]                  m_axis_tdata,   // unit_cost[47:0], scaled_cost[95:48],
                                                        // phase[97:96]
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ucest_pkg::APB_AW-1:0]  paddr,
  input  logic [ucest_pkg::APB_DW-1:0]  pwdata,
  output logic [ucest_pkg::APB_DW-1:0]  prdata,
  output logic                          pready
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_COST     = 9'b000000010,  // per-unit cost divide
    S_DISPATCH = 9'b000000100,  // act on the cost by phase
    S_SCAN_MIN = 9'b000001000,  // ram sweep for the minimum
    S_SCAN_SUM = 9'b000010000,  // ram sweep summing qualifying samples
    S_MEAN     = 9'b000100000,  // sum / count divide
    S_AVG      = 9'b001000000,  // moving average divide
    S_MUL      = 9'b010000000,  // pool scaling
    S_OUT      = 9'b100000000   // hand result to output register
  } state_t;

  state_t                             state;
  ucest_pkg::phase_t                  phase;
  logic [ucest_pkg::CNT_W-1:0]        smp_cnt;
  logic [ucest_pkg::COST_W-1:0]       estimate;
  logic [ucest_pkg::COST_W-1:0]       initial_cost;
  logic [ucest_pkg::SCALE_W-1:0]      pool_scale;

  // seed scan
  logic [ucest_pkg::CNT_W-1:0]        scan_idx;
  logic                               rd_vld;
  logic [ucest_pkg::COST_W-1:0]       min_cost;
  logic [ucest_pkg::LIM_W-1:0]        lim;
  logic [ucest_pkg::SUM_W-1:0]        sum;
  logic [ucest_pkg::CNT_W-1:0]        num;
  logic                               scan_busy;
  logic                               scan_end;

  // sample ram
  logic                               ram_we;
  logic                               ram_re;
  logic [ucest_pkg::COST_W-1:0]       ram_rdata;

  // divider
  ucest_pkg::div_req_t                div_req;
  ucest_pkg::div_rsp_t                div_rsp;

  logic                               in_xfer;
  logic                               cfg_wr;
  ucest_pkg::reg_idx_t                cfg_idx;
  logic [ucest_pkg::COST_W-1:0]       cost;
  logic [ucest_pkg::LIM_W-1:0]        est10;
  logic [ucest_pkg::LIM_W-1:0]        est9;
  logic [ucest_pkg::LIM_W-1:0]        min10;
  logic                               keep_cost;
  logic [ucest_pkg::COST_W-1:0]       avg_sat;
  logic [ucest_pkg::PROD_W-1:0]       prod;
  logic [ucest_pkg::COST_W-1:0]       scaled_sat;

  logic [ucest_pkg::COST_W-1:0]       out_cost;
  logic [ucest_pkg::COST_W-1:0]       out_scaled;
  ucest_pkg::phase_t                  out_phase;

  // ---------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------
  assign s_axis_tready = (state == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = ucest_pkg::reg_idx_t'(paddr[ucest_pkg::CFG_IDX_BIT]);

  always_comb begin
    unique case (cfg_idx)
      ucest_pkg::REG_INITIAL_COST: prdata = ucest_pkg::APB_DW'(initial_cost);
      ucest_pkg::REG_POOL_SCALE:   prdata = ucest_pkg::APB_DW'(pool_scale);
      default:                     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // datapath helpers
  // ---------------------------------------------------------------------
  // cost of the current item, held by the divider until the next start
  assign cost  = div_rsp.quotient[ucest_pkg::COST_W-1:0];
  assign est10 = ({4'b0, estimate} << 3) + ({4'b0, estimate} << 1);
  assign est9  = ({4'b0, estimate} << 3) + {4'b0, estimate};
  assign min10 = ({4'b0, min_cost} << 3) + ({4'b0, min_cost} << 1);
  // outliers beyond ten times the estimate leave it alone
  assign keep_cost = ({4'b0, cost} <= est10);

  // moving average may exceed 48 bits, clamp
  assign avg_sat = (|div_rsp.quotient[ucest_pkg::DIV_W-1:ucest_pkg::COST_W]) ?
                   ucest_pkg::COST_MAX : div_rsp.quotient[ucest_pkg::COST_W-1:0];

  // q8.8 scaling: drop eight fraction bits, clamp the rest
  assign scaled_sat = (|prod[ucest_pkg::PROD_W-1:ucest_pkg::COST_W+8]) ?
                      ucest_pkg::COST_MAX : prod[ucest_pkg::COST_W+7:8];

  assign scan_busy = (state == S_SCAN_MIN) || (state == S_SCAN_SUM);
  assign ram_re    = scan_busy && (scan_idx < ucest_pkg::CNT_W'(ucest_pkg::SAMPLES));
  assign scan_end  = (scan_idx == ucest_pkg::CNT_W'(ucest_pkg::SAMPLES)) && !rd_vld;
  assign ram_we    = (state == S_DISPATCH) && (phase == ucest_pkg::PH_INIT) &&
                     (smp_cnt < ucest_pkg::CNT_W'(ucest_pkg::SAMPLES));

  // divider request: cost on transfer, average in tracking, mean after scan
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    if (in_xfer) begin
      div_req.start    = 1'b1;
      div_req.dividend = ucest_pkg::DIV_W'(s_axis_tdata[47:0]);
      div_req.divisor  = (s_axis_tdata[78:48] == '0) ? ucest_pkg::DVS_W'(1) :
                         s_axis_tdata[78:48];
    end else if ((state == S_DISPATCH) && (phase != ucest_pkg::PH_WAIT) &&
                 (phase != ucest_pkg::PH_INIT) && keep_cost) begin
      div_req.start    = 1'b1;
      div_req.dividend = ucest_pkg::DIV_W'(est9) + ucest_pkg::DIV_W'(cost);
      div_req.divisor  = ucest_pkg::DVS_W'(ucest_pkg::AVG_DIVISOR);
    end else if ((state == S_SCAN_SUM) && scan_end && (num != '0)) begin
      div_req.start    = 1'b1;
      div_req.dividend = ucest_pkg::DIV_W'(sum);
      div_req.divisor  = ucest_pkg::DVS_W'(num);
    end
  end

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      phase         <= ucest_pkg::PH_WAIT;
      smp_cnt       <= '0;
      estimate      <= ucest_pkg::INITIAL_COST_RST;
      initial_cost  <= ucest_pkg::INITIAL_COST_RST;
      pool_scale    <= ucest_pkg::POOL_SCALE_RST;
      scan_idx      <= '0;
      rd_vld        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      rd_vld <= ram_re;
      if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      // register writes must arrive only while idle; the block does not enforce it
      if (cfg_wr) begin
        unique case (cfg_idx)
          ucest_pkg::REG_INITIAL_COST: begin
            initial_cost <= pwdata[ucest_pkg::COST_W-1:0];
            if (phase != ucest_pkg::PH_WORK) begin
              estimate <= pwdata[ucest_pkg::COST_W-1:0];
            end
          end
          ucest_pkg::REG_POOL_SCALE: begin
            pool_scale <= pwdata[ucest_pkg::SCALE_W-1:0];
          end
          default: begin
          end
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            state <= S_COST;
          end
        end
        S_COST: begin
          if (div_rsp.done) begin
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          unique case (phase)
            ucest_pkg::PH_WAIT: begin
              // drop the measurement, count up to one past the sample count
              if (smp_cnt < ucest_pkg::CNT_W'(ucest_pkg::SAMPLES)) begin
                smp_cnt <= smp_cnt + 1'b1;
              end else begin
                smp_cnt <= '0;
                phase   <= ucest_pkg::PH_INIT;
              end
              state <= S_MUL;
            end
            ucest_pkg::PH_INIT: begin
              if (smp_cnt < ucest_pkg::CNT_W'(ucest_pkg::SAMPLES)) begin
                smp_cnt <= smp_cnt + 1'b1;
                state   <= S_MUL;
              end else begin
                scan_idx <= '0;
                state    <= S_SCAN_MIN;
              end
            end
            default: begin
              state <= keep_cost ? S_AVG : S_MUL;
            end
          endcase
        end
        S_SCAN_MIN: begin
          if (ram_re) begin
            scan_idx <= scan_idx + 1'b1;
          end
          if (scan_end) begin
            scan_idx <= '0;
            state    <= S_SCAN_SUM;
          end
        end
        S_SCAN_SUM: begin
          if (ram_re) begin
            scan_idx <= scan_idx + 1'b1;
          end
          if (scan_end) begin
            // nothing below the limit seeds a zero estimate
            if (num == '0) begin
              estimate <= '0;
              phase    <= ucest_pkg::PH_WORK;
              state    <= S_MUL;
            end else begin
              state <= S_MEAN;
            end
          end
        end
        S_MEAN: begin
          if (div_rsp.done) begin
            estimate <= div_rsp.quotient[ucest_pkg::COST_W-1:0];
            phase    <= ucest_pkg::PH_WORK;
            state    <= S_MUL;
          end
        end
        S_AVG: begin
          if (div_rsp.done) begin
            estimate <= avg_sat;
            state    <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_OUT;
        end
        S_OUT: begin
          // wait here only if the previous result is still unclaimed
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // scan accumulators and product, no reset needed
  always_ff @(posedge clk) begin
    if (state == S_DISPATCH) begin
      min_cost <= ucest_pkg::COST_MAX;
      sum      <= '0;
      num      <= '0;
    end
    if ((state == S_SCAN_MIN) && rd_vld && (ram_rdata < min_cost)) begin
      min_cost <= ram_rdata;
    end
    if ((state == S_SCAN_MIN) && scan_end) begin
      lim <= min10;
    end
    if ((state == S_SCAN_SUM) && rd_vld && ({4'b0, ram_rdata} < lim)) begin
      sum <= sum + ucest_pkg::SUM_W'(ram_rdata);
      num <= num + 1'b1;
    end
    if (state == S_MUL) begin
      prod <= ucest_pkg::PROD_W'(estimate) * ucest_pkg::PROD_W'(pool_scale);
    end
    if ((state == S_OUT) && (!m_axis_tvalid || m_axis_tready)) begin
      out_cost   <= estimate;
      out_scaled <= scaled_sat;
      out_phase  <= phase;
    end
  end

  assign m_axis_tdata = {6'b0, out_phase, out_scaled, out_cost};

  // ---------------------------------------------------------------------
  // sample ram and shared divider
  // ---------------------------------------------------------------------
  ucest_ram #(
    .DATA_W (ucest_pkg::COST_W),
    .DEPTH  (ucest_pkg::SAMPLES),
    .ADDR_W (ucest_pkg::SMP_AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (smp_cnt[ucest_pkg::SMP_AW-1:0]),
    .wdata (cost),
    .re    (ram_re),
    .raddr (scan_idx[ucest_pkg::SMP_AW-1:0]),
    .rdata (ram_rdata)
  );

  ucest_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  // every accepted measurement starts the cost divide
  `UCEST_ASSERT_RST(a_xfer_to_cost, clk, rst, in_xfer |=> (state == S_COST))
  // tracking phase is never left
  `UCEST_ASSERT_RST(a_work_sticky, clk, rst,
                    (phase == ucest_pkg::PH_WORK) |=> (phase == ucest_pkg::PH_WORK))
  // samples are only stored while collecting, within the ram
  `UCEST_ASSERT_ALWAYS(a_ram_write_phase, clk,
                       ram_we |-> ((phase == ucest_pkg::PH_INIT) &&
                                   (smp_cnt < ucest_pkg::CNT_W'(ucest_pkg::SAMPLES))))

endmodule

### hw/rtl/ucest_ram.sv
// ---------------------------------------------------------------------------
// ucest_ram
// simple dual port synchronous ram, registered read data
// ---------------------------------------------------------------------------
module ucest_ram #(
  parameter int DATA_W = 48,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/ucest_div.sv
// ---------------------------------------------------------------------------
// ucest_div
// restoring unsigned divider, two quotient bits per cycle
// ---------------------------------------------------------------------------
module ucest_div (
  input  logic                clk,
  input  logic                rst,
  input  ucest_pkg::div_req_t req,
  output ucest_pkg::div_rsp_t rsp
);

  logic                          busy;
  logic                          done;
  logic [ucest_pkg::STEP_W-1:0]  step;
  logic [ucest_pkg::DVS_W-1:0]   dvs;
  logic [ucest_pkg::DVS_W-1:0]   rem;
  logic [ucest_pkg::DIV_W-1:0]   quo;

  logic [ucest_pkg::DVS_W:0]     r1;
  logic [ucest_pkg::DVS_W:0]     r1s;
  logic [ucest_pkg::DVS_W:0]     r2;
  logic [ucest_pkg::DVS_W:0]     r2s;
  logic                          ge1;
  logic                          ge2;

  always_comb begin
    r1  = {rem, quo[ucest_pkg::DIV_W-1]};
    ge1 = (r1 >= {1'b0, dvs});
    r1s = ge1 ? (r1 - {1'b0, dvs}) : r1;
    r2  = {r1s[ucest_pkg::DVS_W-1:0], quo[ucest_pkg::DIV_W-2]};
    ge2 = (r2 >= {1'b0, dvs});
    r2s = ge2 ? (r2 - {1'b0, dvs}) : r2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == ucest_pkg::STEP_W'(ucest_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvs <= req.divisor;
      rem <= '0;
      quo <= req.dividend;
    end else if (busy) begin
      rem <= r2s[ucest_pkg::DVS_W-1:0];
      quo <= {quo[ucest_pkg::DIV_W-3:0], ge1, ge2};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

### bench/tb_unit_cost_estimator_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_unit_cost_estimator_core
// self-checking bench for the per-unit cost estimator
// ---------------------------------------------------------------------------
// Measurements go in over the slave stream and every result transfer is
// compared field by field with a cycle-free model of the estimator kept in
// this file. A short table walks the waiting phase with typed-in results
// and register extremes. Random traffic then fills the sample store,
// triggers the seeding step and runs a long tracking phase. Register writes
// are made only with the block drained. Both stream sides idle at random,
// and the result side holds off once for a long stretch.
// ---------------------------------------------------------------------------
module tb_unit_cost_estimator_core;
  import ucest_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 120;     // longer than the seeding step
  localparam int TRACK_ITEMS = 960;

  // one result transfer as seen on m_axis_tdata
  typedef struct packed {
    logic [COST_W-1:0] unit_cost;
    logic [COST_W-1:0] scaled_cost;
    phase_t            phase;
  } cost_result_t;

  typedef enum logic {ROW_MEAS, ROW_CFG} row_kind_t;

  // one line of the directed table
  typedef struct {
    row_kind_t          kind;
    reg_idx_t           reg_sel;
    logic [63:0]        val;
    logic [COST_W-1:0]  elapsed;
    logic [COUNT_W-1:0] units;
    bit                 typed;
    cost_result_t       want;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [79:0]         s_axis_tdata = '0;   // elapsed_ns[47:0], unit_count[78:48]
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [103:0]        m_axis_tdata;        // unit_cost[47:0], scaled_cost[95:48],
                                            // phase[97:96]
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  unit_cost_estimator_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // estimator copy: registers, phase, sample store and running estimate
  logic [COST_W-1:0]  est_initial_cost = INITIAL_COST_RST;
  logic [SCALE_W-1:0] est_pool_scale   = POOL_SCALE_RST;
  phase_t             est_phase        = PH_WAIT;
  logic [CNT_W-1:0]   est_count        = '0;
  logic [COST_W-1:0]  est_samples [SAMPLES];
  logic [COST_W-1:0]  est_value        = INITIAL_COST_RST;

  cost_result_t pending_estimates [$];
  plan_row_t    plan [$];

  int meas_sent = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int mismatches = 0;
  int avg_updates = 0;
  int outliers_held = 0;
  logic [COST_W-1:0] seeded_value = '0;

  int unsigned burst_left = 0;
  bit          hold_toggle = 1'b0;

  // per-unit cost, phase step and estimate update for one measurement
  function automatic cost_result_t advance_estimator(input logic [COST_W-1:0] e,
                                                     input logic [COUNT_W-1:0] n);
    logic [63:0] cost, lim, sum, avg, prod, mn;
    int          num;
    cost_result_t r;
    cost = {16'b0, e} / ((n == 0) ? 64'd1 : {33'b0, n});
    case (est_phase)
      PH_WAIT: begin
        if (est_count < SAMPLES) begin
          est_count++;
        end else begin
          est_count = '0;
          est_phase = PH_INIT;
        end
      end
      PH_INIT: begin
        if (est_count < SAMPLES) begin
          est_samples[est_count] = cost[COST_W-1:0];
          est_count++;
        end else begin
          // mean of the samples below ten times the smallest one
          mn = {16'b0, est_samples[0]};
          for (int i = 1; i < SAMPLES; i++)
            if (est_samples[i] < mn) mn = {16'b0, est_samples[i]};
          lim = mn * OUTLIER_RATIO;
          sum = '0;
          num = 0;
          for (int i = 0; i < SAMPLES; i++) begin
            if ({16'b0, est_samples[i]} < lim) begin
              sum += {16'b0, est_samples[i]};
              num++;
            end
          end
          est_value    = (num == 0) ? '0 : COST_W'(sum / num);
          seeded_value = est_value;
          est_phase    = PH_WORK;
        end
      end
      default: begin
        // tracking; a code of three would land here as well
        if (cost <= {16'b0, est_value} * OUTLIER_RATIO) begin
          avg = ({16'b0, est_value} * 9 + cost) / AVG_DIVISOR;
          est_value = (avg > {16'b0, COST_MAX}) ? COST_MAX : avg[COST_W-1:0];
          avg_updates++;
        end else begin
          outliers_held++;
        end
      end
    endcase
    prod = ({16'b0, est_value} * {48'b0, est_pool_scale}) >> 8;
    r.unit_cost   = est_value;
    r.scaled_cost = (prod > {16'b0, COST_MAX}) ? COST_MAX : prod[COST_W-1:0];
    r.phase       = est_phase;
    return r;
  endfunction

  // elapsed time and unit count that give the wanted per-unit cost
  function automatic void make_meas(input logic [63:0] cost, output logic [COST_W-1:0] e,
                                    output logic [COUNT_W-1:0] n);
    int unsigned nb, k;
    logic [63:0] t, units;
    t  = cost;
    nb = 0;
    while (t != 0) begin
      nb++;
      t = t >> 1;
    end
    k = (nb >= 47) ? 0 : 47 - nb;
    if (k > 30) k = 30;
    if ($urandom_range(0, 4) == 0) begin
      n = COUNT_W'($urandom_range(0, 1));
    end else begin
      n = COUNT_W'($urandom_range(1, 1 << $urandom_range(0, k)));
    end
    units = (n == 0) ? 64'd1 : {33'b0, n};
    e = COST_W'(cost * units + ($urandom % units));
  endfunction

  function automatic void plan_meas(input logic [COST_W-1:0] e, input logic [COUNT_W-1:0] n,
                                    input bit typed, input logic [COST_W-1:0] uc,
                                    input logic [COST_W-1:0] sc, input phase_t ph);
    plan_row_t row;
    row.kind    = ROW_MEAS;
    row.reg_sel = REG_INITIAL_COST;
    row.val     = '0;
    row.elapsed = e;
    row.units   = n;
    row.typed   = typed;
    row.want    = '{unit_cost: uc, scaled_cost: sc, phase: ph};
    plan.push_back(row);
  endfunction

  function automatic void plan_cfg(input reg_idx_t idx, input logic [63:0] val);
    plan_row_t row;
    row.kind    = ROW_CFG;
    row.reg_sel = idx;
    row.val     = val;
    row.elapsed = '0;
    row.units   = '0;
    row.typed   = 1'b0;
    row.want    = '0;
    plan.push_back(row);
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endtask

  // one measurement transfer, then the sender's burst and gap pattern;
  // entered and left at a falling edge
  task automatic send_meas(input logic [COST_W-1:0] e, input logic [COUNT_W-1:0] n,
                           input bit typed, input cost_result_t want);
    cost_result_t r;
    int unsigned  gap;
    s_axis_tdata  <= {1'b0, n, e};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (s_axis_tready !== 1'b1) @(posedge clk);
    r = advance_estimator(e, n);
    pending_estimates.push_back(typed ? want : r);
    meas_sent++;
    @(negedge clk);
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 140) : $urandom_range(0, 6);
    end else begin
      burst_left--;
    end
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // stop offering and wait until every pending result has been taken
  task automatic quiesce();
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    while (pending_estimates.size() != 0) @(negedge clk);
  endtask

  // register write followed by a read back of the same register
  task automatic cfg_write(input reg_idx_t idx, input logic [63:0] val);
    logic [APB_AW-1:0] addr;
    logic [63:0]       want;
    addr = '0;
    addr[CFG_IDX_BIT] = idx;
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_INITIAL_COST) begin
      est_initial_cost = val[COST_W-1:0];
      // the estimate follows the register until tracking starts
      if (est_phase != PH_WORK) est_value = est_initial_cost;
    end else begin
      est_pool_scale = val[SCALE_W-1:0];
    end
    cfg_writes++;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    want = (idx == REG_INITIAL_COST) ? {16'b0, est_initial_cost} : {48'b0, est_pool_scale};
    if (prdata !== want)
      note_mismatch($sformatf("read back of %s: expected %0d, got %0d", idx.name(), want,
                              prdata));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // result side: stall pattern of its own, plus one long hold-off on request
  bit          rx_hold_seen = 1'b0;
  int unsigned rx_hold_cycles = 0;
  logic [15:0] rx_pattern = '1;
  int unsigned rx_pos = 0;

  always @(negedge clk) begin
    if (rx_hold_seen != hold_toggle) begin
      rx_hold_seen   = hold_toggle;
      rx_hold_cycles = HOLD_CYCLES;
    end
    if (rx_hold_cycles != 0) begin
      rx_hold_cycles--;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_pos == 0) rx_pattern = ($urandom_range(0, 3) == 0) ? '1 : ($urandom | 16'h0001);
      m_axis_tready <= rx_pattern[rx_pos % 16];
      rx_pos = (rx_pos + 1) % 64;
    end
  end

  // result checking against the oldest pending estimate
  always @(posedge clk) begin : result_check
    cost_result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.unit_cost   = m_axis_tdata[47:0];
      got.scaled_cost = m_axis_tdata[95:48];
      got.phase       = phase_t'(m_axis_tdata[97:96]);
      if (pending_estimates.size() == 0) begin
        note_mismatch($sformatf("result transfer with nothing pending: cost %0d scaled %0d",
                                got.unit_cost, got.scaled_cost));
      end else begin
        want = pending_estimates.pop_front();
        results_seen++;
        if (got.unit_cost !== want.unit_cost || got.scaled_cost !== want.scaled_cost ||
            got.phase !== want.phase)
          note_mismatch($sformatf({"result %0d: unit_cost exp %0d got %0d, ",
                                   "scaled_cost exp %0d got %0d, phase exp %0d got %0d"},
                                  results_seen, want.unit_cost, got.unit_cost,
                                  want.scaled_cost, got.scaled_cost, want.phase, got.phase));
      end
    end
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT,
             pending_estimates.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [63:0]        base, c, est;
    logic [COST_W-1:0]  e;
    logic [COUNT_W-1:0] n;
    int unsigned        nb, sel;

    // waiting phase: the estimate is the initial_cost register throughout
    plan_meas(48'd0, 31'd0, 1, 48'd10000, 48'd10000, PH_WAIT);
    plan_meas(COST_MAX, 31'd0, 1, 48'd10000, 48'd10000, PH_WAIT);
    plan_meas(COST_MAX, 31'h7FFF_FFFF, 1, 48'd10000, 48'd10000, PH_WAIT);
    plan_meas(48'd0, 31'h7FFF_FFFF, 1, 48'd10000, 48'd10000, PH_WAIT);
    plan_cfg(REG_POOL_SCALE, 64'd0);
    plan_meas(48'd123456789, 31'd1, 1, 48'd10000, 48'd0, PH_WAIT);
    plan_cfg(REG_INITIAL_COST, {16'b0, COST_MAX});
    plan_meas(48'hAAAA_AAAA_AAAA, 31'h5555_5555, 1, COST_MAX, 48'd0, PH_WAIT);
    // largest estimate and scale: scaled output saturates
    plan_cfg(REG_POOL_SCALE, 64'hFFFF);
    plan_meas(48'h5555_5555_5555, 31'h2AAA_AAAA, 1, COST_MAX, COST_MAX, PH_WAIT);
    plan_cfg(REG_INITIAL_COST, 64'd0);
    plan_meas(48'd1, 31'd1, 1, 48'd0, 48'd0, PH_WAIT);
    plan_cfg(REG_INITIAL_COST, 64'd12345);
    plan_cfg(REG_POOL_SCALE, 64'd512);
    plan_meas(48'd1000, 31'd3, 1, 48'd12345, 48'd24690, PH_WAIT);
    plan_cfg(REG_POOL_SCALE, 64'd128);
    plan_meas(48'd999, 31'd0, 1, 48'd12345, 48'd6172, PH_WAIT);
    plan_meas(48'h0000_FFFF_0000, 31'd1, 0, '0, '0, PH_WAIT);
    plan_meas(48'h1234_5678_9ABC, 31'h100, 0, '0, '0, PH_WAIT);
    plan_meas(48'd77, 31'd7, 0, '0, '0, PH_WAIT);
    plan_meas(48'hFFFF_0000_FFFF, 31'h4000_0000, 0, '0, '0, PH_WAIT);
    plan_meas(48'd5, 31'd6, 0, '0, '0, PH_WAIT);
    plan_meas(48'h8000_0000_0000, 31'd2, 0, '0, '0, PH_WAIT);
    plan_cfg(REG_INITIAL_COST, 64'd10000);
    plan_cfg(REG_POOL_SCALE, 64'd256);
    // the seventeenth measurement moves the block on to collecting
    plan_meas(48'd2000, 31'd0, 1, 48'd10000, 48'd10000, PH_INIT);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        quiesce();
        cfg_write(plan[i].reg_sel, plan[i].val);
      end else begin
        send_meas(plan[i].elapsed, plan[i].units, plan[i].typed, plan[i].want);
      end
    end

    // collecting phase: costs around one base value, a few far above it,
    // never zero so the seeded estimate stays usable
    nb   = $urandom_range(4, 42);
    base = ({$urandom, $urandom} & ((64'd1 << nb) - 1)) | (64'd1 << (nb - 1));
    for (int i = 0; i < SAMPLES; i++) begin
      if (i == SAMPLES / 2) begin
        // mid-collection write also reloads the estimate
        quiesce();
        cfg_write(REG_INITIAL_COST, {16'b0, $urandom, 16'($urandom)});
        cfg_write(REG_POOL_SCALE, 64'($urandom_range(0, 16'hFFFF)));
      end
      if ($urandom_range(0, 15) < 3) begin
        c = base * $urandom_range(25, 60);
      end else begin
        c = base + {$urandom, $urandom} % (base + 1);
      end
      make_meas(c, e, n);
      send_meas(e, n, 0, '0);
    end
    // seeding measurement
    make_meas(base, e, n);
    send_meas(e, n, 0, '0);

    // tracking phase: mostly costs near the estimate, pushes up and down,
    // outliers on and past the ten-times boundary, and raw noise
    for (int i = 0; i < TRACK_ITEMS; i++) begin
      if (i % 120 == 119) begin
        quiesce();
        sel = $urandom_range(0, 3);
        c = (sel == 0) ? 64'd0 : (sel == 1) ? {16'b0, COST_MAX} : {16'b0, $urandom, 16'($urandom)};
        cfg_write(REG_INITIAL_COST, c);
        sel = $urandom_range(0, 3);
        c = (sel == 0) ? 64'd0 : (sel == 1) ? 64'hFFFF : (sel == 2) ? 64'd256 :
            64'($urandom_range(0, 16'hFFFF));
        cfg_write(REG_POOL_SCALE, c);
      end
      // result side holds off while measurements keep coming
      if (i == 300) hold_toggle = ~hold_toggle;
      est = {16'b0, est_value};
      sel = $urandom_range(0, 99);
      // a small estimate only ever gets pushed up, so it cannot collapse to zero
      if (est < 1000) sel = 65;
      if (sel >= 88) begin
        e = COST_W'({$urandom, $urandom});
        case ($urandom_range(0, 2))
          0:       n = '0;
          1:       n = COUNT_W'($urandom_range(1, 255));
          default: n = COUNT_W'($urandom);
        endcase
      end else begin
        if (sel < 60) begin
          c = est / 2 + {$urandom, $urandom} % (est + 1);
        end else if (sel < 70) begin
          c = est * $urandom_range(5, 10);
        end else if (sel < 80) begin
          c = est / $urandom_range(2, 10);
        end else if ($urandom_range(0, 1) == 0) begin
          c = est * OUTLIER_RATIO;
        end else begin
          c = est * OUTLIER_RATIO + 1 + $urandom_range(0, 1000);
        end
        if (c > {16'b0, COST_MAX}) c = {16'b0, COST_MAX};
        make_meas(c, e, n);
      end
      send_meas(e, n, 0, '0);
    end

    quiesce();
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("run covered %0d measurements, %0d results checked, %0d register writes",
             meas_sent, results_seen, cfg_writes);
    $display("seeded estimate %0d, then %0d averaged updates and %0d outliers held back",
             seeded_value, avg_updates, outliers_held);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### unit_cost_estimator_core.f
+incdir+hw/rtl
hw/rtl/ucest_pkg.sv
hw/rtl/ucest_ram.sv
hw/rtl/ucest_div.sv
hw/rtl/unit_cost_estimator_core.sv
bench/tb_unit_cost_estimator_core.sv
